// File: hw/rtl/rqr_pkg.sv
// ----------------------------------------------------------------------------
// rqr_pkg
// Shared types and constants for the run queue with delete by key.
// ----------------------------------------------------------------------------
package rqr_pkg;

  // Default sizing
  localparam int unsigned DefQueueDepth = 16;
  localparam int unsigned DefIdWidth    = 16;

  // Fixed port widths
  localparam int unsigned PortIdW   = 16;
  localparam int unsigned KindW     = 2;
  localparam int unsigned StatusW   = 2;

  // Operation codes
  typedef enum logic [KindW-1:0] {
    KIND_APPEND = 2'd0,
    KIND_TAKE   = 2'd1,
    KIND_REMOVE = 2'd2
  } kind_e;

  // Result status codes
  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  // Per-operation strobes broadcast to every cell, already qualified
  typedef struct packed {
    logic do_append;
    logic do_take;
    logic do_remove;
  } cell_ctrl_t;

endpackage

// File: hw/rtl/rqr_cell.sv
// ----------------------------------------------------------------------------
// rqr_cell
// One queue slot: holds an identifier and its valid bit, compares against the
// broadcast key, and shifts in its right neighbor when the queue closes up.
// ----------------------------------------------------------------------------
module rqr_cell
  import rqr_pkg::*;
#(
  parameter int unsigned ID_WIDTH = DefIdWidth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cell_ctrl_t          ctrl_i,
  input  logic [ID_WIDTH-1:0] id_i,
  input  logic                left_valid_i,
  input  logic                left_hit_i,
  input  logic                right_valid_i,
  input  logic [ID_WIDTH-1:0] right_entry_i,
  output logic                valid_o,
  output logic [ID_WIDTH-1:0] entry_o,
  output logic                hit_o
);

  logic                valid_q, valid_d;
  logic [ID_WIDTH-1:0] entry_q, entry_d;
  logic                match;
  logic                shift;
  logic                load;

  // Key compare and first-match chain toward the tail
  assign match = valid_q && (entry_q == id_i);
  assign hit_o = left_hit_i | match;

  // Shift on take, or on removal at or behind the first match
  assign shift = ctrl_i.do_take | (ctrl_i.do_remove & hit_o);
  // This cell is the first free slot
  assign load  = ctrl_i.do_append & left_valid_i & ~valid_q;

  always_comb begin
    valid_d = valid_q;
    entry_d = entry_q;
    if (shift) begin
      valid_d = right_valid_i;
      entry_d = right_entry_i;
    end else if (load) begin
      valid_d = 1'b1;
      entry_d = id_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign valid_o = valid_q;
  assign entry_o = entry_q;

endmodule

// File: hw/rtl/run_queue_with_removal_core.sv
// ----------------------------------------------------------------------------
// run_queue_with_removal_core
// Ordered run queue of process identifiers: append at tail, take head, or
// remove the first matching entry; later entries close the gap.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake                 | Payload
//  --------+-----------+---------------------------+---------------------------
//  in      | input     | in_valid_i / in_stall_o   | kind_i, proc_id_i
//  out     | output    | out_valid_o / out_stall_i | taken_id_o, status_o, count_o
//
//  One operation per cycle; its result is registered and appears the cycle after
//  the input transfer. The row of cells compares the key in parallel and the
//  first-match flag ripples along the row, which sets the cycle's depth.
//  Reset clears all valid bits and the entry count; stored identifiers are
//  not cleared. While a result is held by out_stall_i, in_stall_o is high.
// ----------------------------------------------------------------------------
module run_queue_with_removal_core
  import rqr_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = DefQueueDepth,
  parameter int unsigned ID_WIDTH    = DefIdWidth,
  localparam int unsigned CountW     = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [KindW-1:0]   kind_i,
  input  logic [PortIdW-1:0] proc_id_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [PortIdW-1:0] taken_id_o,
  output logic [StatusW-1:0] status_o,
  output logic [CountW-1:0]  count_o
);

  logic                in_xfer;
  logic [ID_WIDTH-1:0] key;
  logic                full, empty, found;
  cell_ctrl_t          ctrl;
  logic [CountW-1:0]   count_q, count_d;
  logic                out_valid_q;
  logic [PortIdW-1:0]  taken_q, taken_d;
  status_e             status_q, status_d;

  logic                cell_valid [QUEUE_DEPTH];
  logic [ID_WIDTH-1:0] cell_entry [QUEUE_DEPTH];
  logic                cell_hit   [QUEUE_DEPTH];

  // Input transfer; hold off while a result waits
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_xfer    = in_valid_i & ~in_stall_o;
  assign key        = ID_WIDTH'(proc_id_i);

  assign full  = (count_q == CountW'(QUEUE_DEPTH));
  assign empty = (count_q == '0);
  assign found = cell_hit[QUEUE_DEPTH-1];

  // Decode operation into cell strobes, status and new count
  always_comb begin
    ctrl     = '0;
    count_d  = count_q;
    taken_d  = '0;
    status_d = ST_OK;
    unique case (kind_i)
      KIND_APPEND: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          ctrl.do_append = in_xfer;
          count_d        = count_q + 1'b1;
        end
      end
      KIND_TAKE: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          ctrl.do_take = in_xfer;
          taken_d      = PortIdW'(cell_entry[0]);
          count_d      = count_q - 1'b1;
        end
      end
      KIND_REMOVE: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else if (found) begin
          ctrl.do_remove = in_xfer;
          count_d        = count_q - 1'b1;
        end else begin
          status_d = ST_NOT_FOUND;
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  // Row of cells, head at index zero
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                left_valid, left_hit, right_valid;
    logic [ID_WIDTH-1:0] right_entry;

    if (i == 0) begin : g_head
      assign left_valid = 1'b1;
      assign left_hit   = 1'b0;
    end else begin : g_body
      assign left_valid = cell_valid[i-1];
      assign left_hit   = cell_hit[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_valid = 1'b0;
      assign right_entry = '0;
    end else begin : g_inner
      assign right_valid = cell_valid[i+1];
      assign right_entry = cell_entry[i+1];
    end

    rqr_cell #(
      .ID_WIDTH(ID_WIDTH)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .id_i         (key),
      .left_valid_i (left_valid),
      .left_hit_i   (left_hit),
      .right_valid_i(right_valid),
      .right_entry_i(right_entry),
      .valid_o      (cell_valid[i]),
      .entry_o      (cell_entry[i]),
      .hit_o        (cell_hit[i])
    );
  end

  // Count and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        count_q <= count_d;
      end
      if (in_xfer) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      taken_q  <= taken_d;
      status_q <= status_d;
    end
  end

  logic [CountW-1:0] count_out_q;
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      count_out_q <= count_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign taken_id_o  = taken_q;
  assign status_o    = status_q;
  assign count_o     = count_out_q;

endmodule

// File: hw/rtl/rqr_checker.sv
// ----------------------------------------------------------------------------
// rqr_checker
// Port-level checks for the run queue, attached to the top level by bind.
// ----------------------------------------------------------------------------
module rqr_checker
  import rqr_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = DefQueueDepth,
  localparam int unsigned CountW     = $clog2(QUEUE_DEPTH + 1)
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [PortIdW-1:0] taken_id_o,
  input logic [StatusW-1:0] status_o,
  input logic [CountW-1:0]  count_o
);

  // Full refusal only with the queue at capacity
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |-> count_o == CountW'(QUEUE_DEPTH))
    else $error("full status with queue below capacity");

  // Empty status leaves nothing behind
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_EMPTY |-> count_o == '0)
    else $error("empty status with nonzero count");

  // A taken identifier implies a successful operation
  a_taken_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && taken_id_o != '0 |-> status_o == ST_OK)
    else $error("identifier returned with error status");

  // A held result blocks the input side
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input accepted while result held");

  // Stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(taken_id_o)
      && $stable(status_o) && $stable(count_o))
    else $error("stalled result changed");

endmodule

bind run_queue_with_removal_core rqr_checker #(
  .QUEUE_DEPTH(QUEUE_DEPTH)
) u_rqr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .taken_id_o (taken_id_o),
  .status_o   (status_o),
  .count_o    (count_o)
);

// File: bench/run_queue_board_pkg.sv
// ----------------------------------------------------------------------------
// Run queue scoreboard
// Mirrors the run queue contents, predicts the outcome of every accepted
// operation and checks the block's results against them in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package run_queue_board_pkg;
  import rqr_pkg::*;

  // Kind value with no operation behind it; the block must pass it through
  localparam logic [KindW-1:0] KindUnused = 2'd3;
  localparam int unsigned CountW = $clog2(DefQueueDepth + 1);

  typedef struct packed {
    logic [PortIdW-1:0] taken_id;
    status_e            status;
    logic [CountW-1:0]  count;
  } outcome_t;

  class run_queue_board;
    logic [PortIdW-1:0] resident_ids[$];
    outcome_t           pending_outcomes[$];
    int unsigned        depth;
    int unsigned        errors;
    int unsigned        peak;
    int unsigned        kind_seen[4];
    int unsigned        status_seen[4];

    function new(int unsigned depth_i);
      depth  = depth_i;
      errors = 0;
      peak   = 0;
      foreach (kind_seen[k]) kind_seen[k] = 0;
      foreach (status_seen[k]) status_seen[k] = 0;
    endfunction

    // Update the mirror for one accepted operation and queue its outcome
    function void apply_operation(logic [KindW-1:0] kind, logic [PortIdW-1:0] id);
      outcome_t res;
      int       hit;
      res.taken_id = '0;
      res.status   = ST_OK;
      hit          = -1;
      case (kind)
        KIND_APPEND: begin
          if (resident_ids.size() >= depth) res.status = ST_FULL;
          else resident_ids.push_back(id);
        end
        KIND_TAKE: begin
          if (resident_ids.size() == 0) res.status = ST_EMPTY;
          else res.taken_id = resident_ids.pop_front();
        end
        KIND_REMOVE: begin
          if (resident_ids.size() == 0) begin
            res.status = ST_EMPTY;
          end else begin
            // first match from the head wins
            foreach (resident_ids[i]) begin
              if (hit < 0 && resident_ids[i] == id) hit = i;
            end
            if (hit < 0) res.status = ST_NOT_FOUND;
            else resident_ids.delete(hit);
          end
        end
        default: ;  // unused kind: no change, ok status
      endcase
      res.count = CountW'(resident_ids.size());
      if (resident_ids.size() > peak) peak = resident_ids.size();
      kind_seen[kind]++;
      status_seen[int'(res.status)]++;
      pending_outcomes.push_back(res);
    endfunction

    // Compare one result transfer with the oldest outcome
    function void check_outcome(logic [PortIdW-1:0] taken_id, logic [StatusW-1:0] status,
                                logic [CountW-1:0] count);
      outcome_t want;
      if (pending_outcomes.size() == 0) begin
        $error("result with nothing outstanding: taken_id %h status %0d count %0d",
               taken_id, status, count);
        errors++;
        return;
      end
      want = pending_outcomes.pop_front();
      if (taken_id !== want.taken_id) begin
        $error("taken_id: expected %h, got %h", want.taken_id, taken_id);
        errors++;
      end
      if (status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, status);
        errors++;
      end
      if (count !== want.count) begin
        $error("count: expected %0d, got %0d", want.count, count);
        errors++;
      end
    endfunction
  endclass

endpackage

// File: bench/run_queue_with_removal_core_test.sv
// ----------------------------------------------------------------------------
// Run queue with removal: top-level test
// Directed corner operations followed by randomized append/take/remove
// traffic with random idle and stall on both channels, a long output
// hold-off and drain pauses; every result is checked by the scoreboard.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module run_queue_with_removal_core_test;
  import rqr_pkg::*;
  import run_queue_board_pkg::*;

  localparam int unsigned RandomOps     = 1300;
  localparam int unsigned IdlePct       = 37;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned QuietLimit    = 3000;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic [KindW-1:0]   kind_i      = '0;
  logic [PortIdW-1:0] proc_id_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [PortIdW-1:0] taken_id_o;
  logic [StatusW-1:0] status_o;
  logic [CountW-1:0]  count_o;

  bit                 idle_on      = 1'b1;
  bit                 hold_off_req = 1'b0;
  int unsigned        quiet_cycles = 0;
  logic [PortIdW-1:0] id_pool[6];
  run_queue_board     board;

  run_queue_with_removal_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .proc_id_i   (proc_id_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .taken_id_o  (taken_id_o),
    .status_o    (status_o),
    .count_o     (count_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: random stall, or one long hold-off when asked
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        out_stall_i <= 1'b1;
        repeat (HoldOffCycles - 1) @(negedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        out_stall_i <= idle_on && ($urandom_range(99) < IdlePct);
      end
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_outcome(taken_id_o, status_o, count_o);
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Offer one operation at a falling edge and hold it until transfer
  task automatic send_op(input logic [KindW-1:0] kind, input logic [PortIdW-1:0] id);
    while (idle_on && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    proc_id_i  <= id;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    board.apply_operation(kind, id);
    @(negedge clk_i);
  endtask

  // Stop offering until every outstanding result has come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (board.pending_outcomes.size() != 0);
  endtask

  function automatic logic [PortIdW-1:0] pick_id();
    if ($urandom_range(1)) return id_pool[$urandom_range(5)];
    return PortIdW'($urandom());
  endfunction

  initial begin
    int unsigned        append_pct[13];
    int unsigned        sel;
    logic [KindW-1:0]   kind;
    logic [PortIdW-1:0] id;

    board = new(DefQueueDepth);
    append_pct = '{60, 45, 85, 30, 70, 50, 90, 20, 55, 65, 40, 80, 35};
    foreach (id_pool[k]) id_pool[k] = PortIdW'($urandom());

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty cases, fill to full with duplicates, refusal, misses
    send_op(KIND_TAKE, 16'h0000);
    send_op(KIND_REMOVE, 16'hFFFF);
    send_op(KIND_APPEND, 16'h0000);
    send_op(KIND_APPEND, 16'hFFFF);
    for (int k = 0; k < 14; k++) begin
      id = (k == 3 || k == 9) ? 16'h5A5A : PortIdW'(k * 16'h1111 + 16'h0101);
      send_op(KIND_APPEND, id);
    end
    send_op(KIND_APPEND, 16'h8001);      // refused, queue full
    send_op(KIND_REMOVE, 16'h1234);      // no match
    send_op(KIND_REMOVE, 16'h5A5A);      // two matches, nearest head goes
    send_op(KindUnused, 16'hC3C3);
    send_op(KIND_TAKE, 16'hFFFF);        // takes the zero id
    send_op(KIND_REMOVE, 16'hFFFF);      // match at head
    send_op(KIND_REMOVE, 16'hDEDE);      // match at tail

    // Random traffic, append bias swings per phase to sweep occupancy
    for (int i = 0; i < RandomOps; i++) begin
      idle_on = !(i >= 500 && i < 750);
      if (i == 300) hold_off_req = 1'b1;
      if (i == 900 || i == 1200) wait_drained();
      if ($urandom_range(99) < 3) begin
        kind = KindUnused;
        id   = PortIdW'($urandom());
      end else begin
        sel = $urandom_range(99);
        if (sel < append_pct[i / 100]) begin
          kind = KIND_APPEND;
          id   = pick_id();
        end else if ($urandom_range(1)) begin
          kind = KIND_TAKE;
          id   = PortIdW'($urandom());
        end else begin
          kind = KIND_REMOVE;
          if (board.resident_ids.size() != 0 && $urandom_range(99) < 75)
            id = board.resident_ids[$urandom_range(board.resident_ids.size() - 1)];
          else
            id = pick_id();
        end
      end
      send_op(kind, id);
    end

    wait_drained();
    repeat (4) @(posedge clk_i);

    $display("Ran %0d appends, %0d takes, %0d removes, %0d unused kinds; peak depth %0d.",
             board.kind_seen[KIND_APPEND], board.kind_seen[KIND_TAKE],
             board.kind_seen[KIND_REMOVE], board.kind_seen[KindUnused], board.peak);
    $display("Outcomes: ok %0d, empty %0d, full %0d, not found %0d.",
             board.status_seen[ST_OK], board.status_seen[ST_EMPTY],
             board.status_seen[ST_FULL], board.status_seen[ST_NOT_FOUND]);
    if (board.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/rqr_pkg.sv
hw/rtl/rqr_cell.sv
hw/rtl/run_queue_with_removal_core.sv
hw/rtl/rqr_checker.sv
bench/run_queue_board_pkg.sv
bench/run_queue_with_removal_core_test.sv
